// ===== sv/dttu_pkg.sv =====
// shared types, codes and character helpers for the decimal text parser
// no dependencies; used by every module of the block and by the checker
`default_nettype none

package dttu_pkg;

	localparam int DEF_INDEX_BITS = 16;
	localparam int CHAR_W         = 8;
	localparam int VALUE_W        = 64;
	localparam int STATUS_W       = 2;
	localparam int POS_W          = 16;
	localparam int PHASE_W        = 2;
	localparam int DIGIT_W        = 4;

	localparam logic [PHASE_W-1:0] PH_SKIP   = 2'd0;
	localparam logic [PHASE_W-1:0] PH_DIGITS = 2'd1;
	localparam logic [PHASE_W-1:0] PH_DONE   = 2'd2;

	localparam logic [STATUS_W-1:0] ST_OK             = 2'd0;
	localparam logic [STATUS_W-1:0] ST_EXPECTED_DIGIT = 2'd1;
	localparam logic [STATUS_W-1:0] ST_OUT_OF_RANGE   = 2'd2;
	localparam logic [STATUS_W-1:0] ST_EXPECTED_END   = 2'd3;

	localparam logic [CHAR_W-1:0] CHAR_NUL   = 8'h00;
	localparam logic [CHAR_W-1:0] CHAR_TAB   = 8'h09;
	localparam logic [CHAR_W-1:0] CHAR_LF    = 8'h0A;
	localparam logic [CHAR_W-1:0] CHAR_CR    = 8'h0D;
	localparam logic [CHAR_W-1:0] CHAR_SPACE = 8'h20;
	localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
	localparam logic [CHAR_W-1:0] CHAR_NINE  = 8'h39;

	// largest accumulator that still takes another digit (max / 10)
	localparam logic [VALUE_W-1:0]  ACC_LIMIT      = 64'd1844674407370955161;
	localparam logic [DIGIT_W-1:0]  ACC_LIMIT_LAST = 4'd5;
	localparam logic [POS_W-1:0]    POS_MAX        = 16'hFFFF;

	typedef struct packed {
		logic [PHASE_W-1:0] phase;
		logic [VALUE_W-1:0] acc;
	} core_t;

	typedef struct packed {
		logic [VALUE_W-1:0]  value;
		logic [STATUS_W-1:0] status;
		logic [POS_W-1:0]    position;
	} result_t;

	function automatic logic is_space(input logic [CHAR_W-1:0] c);
		return (c == CHAR_SPACE) || (c == CHAR_TAB) || (c == CHAR_LF) || (c == CHAR_CR);
	endfunction

	function automatic logic is_dec_char(input logic [CHAR_W-1:0] c);
		return (c >= CHAR_ZERO) && (c <= CHAR_NINE);
	endfunction

endpackage

`default_nettype wire

// ===== sv/dttu_step.sv =====
// next-state and result logic for one character of the decimal text parser
// depends on dttu_pkg; purely combinational, registered by the top level
`default_nettype none

module dttu_step #(
	parameter int INDEX_BITS = dttu_pkg::DEF_INDEX_BITS
) (
	input  wire logic [dttu_pkg::CHAR_W-1:0] char_code,
	input  wire dttu_pkg::core_t             cur,
	input  wire logic [INDEX_BITS-1:0]       idx,
	output dttu_pkg::core_t                  nxt,
	output logic [INDEX_BITS-1:0]            idx_nxt,
	output logic                             emit,
	output dttu_pkg::result_t                res
);

	logic                             is_nul;
	logic                             space;
	logic                             digit_ok;
	logic [dttu_pkg::CHAR_W-1:0]      digit_full;
	logic [dttu_pkg::DIGIT_W-1:0]     digit;
	logic                             overflow;
	logic [dttu_pkg::VALUE_W-1:0]     acc_times_ten;
	logic [31:0]                      idx_ext;
	dttu_pkg::core_t                  after;

	assign is_nul     = (char_code == dttu_pkg::CHAR_NUL);
	assign space      = dttu_pkg::is_space(char_code);
	assign digit_ok   = dttu_pkg::is_dec_char(char_code);
	assign digit_full = char_code - dttu_pkg::CHAR_ZERO;
	assign digit      = digit_full[dttu_pkg::DIGIT_W-1:0];

	assign overflow = (cur.acc > dttu_pkg::ACC_LIMIT) ||
		((cur.acc == dttu_pkg::ACC_LIMIT) && (digit > dttu_pkg::ACC_LIMIT_LAST));

	// times ten as times eight plus times two
	assign acc_times_ten = {cur.acc[dttu_pkg::VALUE_W-4:0], 3'b000} +
		{cur.acc[dttu_pkg::VALUE_W-2:0], 1'b0};

	// position saturates at the width of the output field
	assign idx_ext = 32'(idx);

	always_comb begin
		after        = cur;
		emit         = 1'b0;
		res.value    = '0;
		res.status   = dttu_pkg::ST_OK;
		res.position = (idx_ext > 32'(dttu_pkg::POS_MAX)) ? dttu_pkg::POS_MAX
			: idx_ext[dttu_pkg::POS_W-1:0];

		case (cur.phase)
			dttu_pkg::PH_SKIP: begin
				if (!is_nul && space) begin
					after = cur;
				end else if (digit_ok) begin
					after.acc   = dttu_pkg::VALUE_W'(digit);
					after.phase = dttu_pkg::PH_DIGITS;
				end else begin
					emit       = 1'b1;
					res.status = dttu_pkg::ST_EXPECTED_DIGIT;
				end
			end
			dttu_pkg::PH_DIGITS: begin
				if (digit_ok) begin
					if (overflow) begin
						after.acc  = '0;
						emit       = 1'b1;
						res.status = dttu_pkg::ST_OUT_OF_RANGE;
					end else begin
						after.acc = acc_times_ten + dttu_pkg::VALUE_W'(digit);
					end
				end else if (is_nul || space) begin
					emit      = 1'b1;
					res.value = cur.acc;
				end else begin
					emit       = 1'b1;
					res.status = dttu_pkg::ST_EXPECTED_END;
				end
			end
			default: begin
				after = cur;
			end
		endcase

		if (emit) begin
			after.phase = dttu_pkg::PH_DONE;
		end

		nxt     = after;
		idx_nxt = idx;
		if (is_nul) begin
			nxt.phase = dttu_pkg::PH_SKIP;
			nxt.acc   = '0;
			idx_nxt   = '0;
		end else if ((after.phase != dttu_pkg::PH_DONE) && (idx != {INDEX_BITS{1'b1}})) begin
			idx_nxt = idx + 1'b1;
		end
	end

endmodule

`default_nettype wire

// ===== sv/decimal_text_to_uint64_parser.sv =====
// top level of the decimal text to unsigned 64-bit parser
// depends on dttu_pkg and dttu_step; input register, parser state and result register
`default_nettype none

// One character is taken per clock on the slave side while no held result stalls it,
// and a result, when the string's outcome is decided, is registered on the master side.
// The rate of one character per cycle is set by the combinational accumulator update
// (times ten by shift and add, plus the exact overflow compare) between the input
// register and the result register. A held result stalls the input side only when the
// character waiting in the input register itself decides a result. A zero byte ends
// a string and returns the parser to its reset state; nothing needs clearing after reset.
module decimal_text_to_uint64_parser #(
	parameter int INDEX_BITS = dttu_pkg::DEF_INDEX_BITS
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [7:0]  s_axis_tdata,   // char_code
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	output logic [79:0]      m_axis_tdata,   // parsed_value, position
	output logic [1:0]       m_axis_tuser    // status
);

	logic                        valid_s1;
	logic [dttu_pkg::CHAR_W-1:0] char_s1;
	dttu_pkg::core_t             core_q;
	logic [INDEX_BITS-1:0]       idx_q;
	logic                        out_valid_q;
	dttu_pkg::result_t           out_res_q;

	dttu_pkg::core_t             core_nxt;
	logic [INDEX_BITS-1:0]       idx_nxt;
	logic                        emit;
	dttu_pkg::result_t           res;
	logic                        out_free;
	logic                        advance;
	logic                        in_beat;

	dttu_step #(
		.INDEX_BITS(INDEX_BITS)
	) u_step (
		.char_code(char_s1),
		.cur      (core_q),
		.idx      (idx_q),
		.nxt      (core_nxt),
		.idx_nxt  (idx_nxt),
		.emit     (emit),
		.res      (res)
	);

	assign out_free      = !out_valid_q || m_axis_tready;
	assign advance       = valid_s1 && (out_free || !emit);
	assign s_axis_tready = !valid_s1 || advance;
	assign in_beat       = s_axis_tvalid && s_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			core_q      <= '{phase: dttu_pkg::PH_SKIP, acc: '0};
			idx_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (s_axis_tready) begin
				valid_s1 <= s_axis_tvalid;
			end
			if (advance) begin
				core_q <= core_nxt;
				idx_q  <= idx_nxt;
			end
			if (advance && emit) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_beat) begin
			char_s1 <= s_axis_tdata;
		end
		if (advance && emit) begin
			out_res_q <= res;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {out_res_q.position, out_res_q.value};
	assign m_axis_tuser  = out_res_q.status;

endmodule

`default_nettype wire

// ===== sv/dttu_checker.sv =====
// port-level checks for the decimal text parser, bound to the top level
// depends on dttu_pkg and decimal_text_to_uint64_parser
`default_nettype none

module dttu_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        s_axis_tvalid,
	input wire logic        s_axis_tready,
	input wire logic [7:0]  s_axis_tdata,
	input wire logic        m_axis_tvalid,
	input wire logic        m_axis_tready,
	input wire logic [79:0] m_axis_tdata,
	input wire logic [1:0]  m_axis_tuser
);

	// input side stalls only behind a held result
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!s_axis_tready |-> (m_axis_tvalid && !m_axis_tready))
		else $error("input stalled without a blocked result");

	// every error carries a zero value
	a_error_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && (m_axis_tuser != dttu_pkg::ST_OK)) |-> (m_axis_tdata[63:0] == 64'd0))
		else $error("error result with non-zero value");

	// a result that is not taken holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && !m_axis_tready) |=>
			(m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)))
		else $error("held result changed");

	// no stall while the master side is empty
	a_source: assert property (@(posedge clk) disable iff (!arst_n)
		(!m_axis_tvalid && !(s_axis_tvalid && s_axis_tready) && !s_axis_tready) |=> 1'b0)
		else $error("stall seen with no result waiting");

endmodule

bind decimal_text_to_uint64_parser dttu_checker u_dttu_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.s_axis_tvalid(s_axis_tvalid),
	.s_axis_tready(s_axis_tready),
	.s_axis_tdata (s_axis_tdata),
	.m_axis_tvalid(m_axis_tvalid),
	.m_axis_tready(m_axis_tready),
	.m_axis_tdata (m_axis_tdata),
	.m_axis_tuser (m_axis_tuser)
);

`default_nettype wire
